// File: hw/rtl/mlt_pkg.sv
// Types, token codes and keyword tables for the map language tokenizer.
`timescale 1ns / 1ps

package mlt_pkg;

    localparam int NUM_WORDS = 8;
    localparam int WORD_CHARS = 6;

    localparam logic [3:0] KIND_END   = 4'd0;
    localparam logic [3:0] KIND_CONST = 4'd1;
    localparam logic [3:0] KIND_SBYTE = 4'd2;
    localparam logic [3:0] KIND_SEND  = 4'd3;
    localparam logic [3:0] KIND_UNDEF = 4'd11;
    localparam logic [3:0] KIND_CHAR  = 4'd12;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_CHARS] = '{
        '{"f", "l", "o", "o", "r", 8'h00},
        '{"l", "i", "n", "e", 8'h00, 8'h00},
        '{"m", "a", "r", "k", 8'h00, 8'h00},
        '{"t", "o", "p", 8'h00, 8'h00, 8'h00},
        '{"b", "o", "t", 8'h00, 8'h00, 8'h00},
        '{"b", "o", "t", "t", "o", "m"},
        '{"l", "e", "f", "t", 8'h00, 8'h00},
        '{"r", "i", "g", "h", "t", 8'h00}
    };
    localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
        3'd5, 3'd4, 3'd4, 3'd3, 3'd3, 3'd6, 3'd4, 3'd5
    };
    localparam logic [3:0] WORD_KIND [NUM_WORDS] = '{
        4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8, 4'd9, 4'd10
    };

    typedef struct packed {
        logic [3:0]  kind;
        logic [30:0] value;
        logic        last;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
    endfunction

    // Drop keywords that cannot match c at position pos.
    function automatic logic [NUM_WORDS-1:0] kw_feed(input logic [NUM_WORDS-1:0] cand,
                                                    input logic [2:0] pos,
                                                    input logic [7:0] c);
        logic [NUM_WORDS-1:0] res;
        res = cand;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (pos >= WORD_LEN[i]) begin
                res[i] = 1'b0;
            end else if (WORD_TEXT[i][pos] != c) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    // First surviving keyword whose length matches, else undefined.
    function automatic logic [3:0] kw_finish(input logic [NUM_WORDS-1:0] cand,
                                            input logic [2:0] len);
        logic [3:0] kind;
        kind = KIND_UNDEF;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (cand[i] && (WORD_LEN[i] == len)) begin
                kind = WORD_KIND[i];
            end
        end
        return kind;
    endfunction

endpackage

// File: hw/rtl/map_language_tokenizer.sv
// Map language tokenizer: character stream in, token stream out.
// A character's results are registered into the result queue when it is accepted.
// Throughput: one character per cycle while s_tready is high; a character that
// ends a token and also yields a token of its own gives two results.
// s_tready is high while the four-entry result queue has at least two free entries.
// Reset (aresetn, synchronous, active low) returns the scanner to idle and
// empties the result queue.
`timescale 1ns / 1ps

module map_language_tokenizer
    import mlt_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] token_value, zero pad
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast
);

    localparam int MW = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_IDENT   = 3'd4
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [NUM_WORDS-1:0]   cand_reg, cand_next;
    logic [2:0]             len_reg, len_next;

    result_t                queue_reg [4];
    logic [1:0]             wr_ptr_reg, rd_ptr_reg;
    logic [2:0]             count_reg;

    logic                   s_accept, m_accept;
    logic [7:0]             c;
    logic                   eoi;

    // Prefix result from the current mode, then result from idle handling.
    logic                   pre_v, idle_v, run_idle;
    logic [3:0]             pre_kind, idle_kind;
    logic [30:0]            pre_value, idle_value;
    mode_t                  idle_mode;
    logic [VALUE_BITS-1:0]  idle_acc;
    logic [NUM_WORDS-1:0]   idle_cand;
    logic [2:0]             idle_len;
    logic [MW-1:0]          acc_sum;
    result_t                res0, res1;
    logic [1:0]             wr_n;

    assign c        = s_tdata;
    assign eoi      = s_tuser;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = (count_reg <= 3'd2);

    assign acc_sum = (MW'(acc_reg) << 3) + (MW'(acc_reg) << 1) + MW'(c[3:0]);

    // Handling of a character seen between tokens.
    always_comb begin
        idle_v     = 1'b0;
        idle_kind  = KIND_END;
        idle_value = '0;
        idle_mode  = MODE_IDLE;
        idle_acc   = acc_reg;
        idle_cand  = cand_reg;
        idle_len   = len_reg;
        if (eoi) begin
            idle_v = 1'b1;
        end else if (is_blank(c)) begin
            idle_v = 1'b0;
        end else if (c == CH_HASH) begin
            idle_mode = MODE_COMMENT;
        end else if (is_digit(c)) begin
            idle_mode = MODE_NUMBER;
            idle_acc  = VALUE_BITS'(c[3:0]);
        end else if (c == CH_QUOTE) begin
            idle_mode = MODE_STRING;
        end else if (is_alpha(c) || c == CH_UNDER) begin
            idle_mode = MODE_IDENT;
            idle_cand = kw_feed({NUM_WORDS{1'b1}}, 3'd0, c);
            idle_len  = 3'd1;
        end else begin
            idle_v     = 1'b1;
            idle_kind  = KIND_CHAR;
            idle_value = 31'(c);
        end
    end

    always_comb begin
        pre_v     = 1'b0;
        pre_kind  = KIND_END;
        pre_value = '0;
        run_idle  = 1'b0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cand_next = cand_reg;
        len_next  = len_reg;
        case (mode_reg)
            MODE_COMMENT: begin
                if (eoi) begin
                    run_idle = 1'b1;
                end else if (c == CH_NEWLINE) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_STRING: begin
                if (eoi) begin
                    pre_v    = 1'b1;
                    pre_kind = KIND_SEND;
                    run_idle = 1'b1;
                end else if (c == CH_QUOTE) begin
                    pre_v     = 1'b1;
                    pre_kind  = KIND_SEND;
                    mode_next = MODE_IDLE;
                end else begin
                    pre_v     = 1'b1;
                    pre_kind  = KIND_SBYTE;
                    pre_value = 31'(c);
                end
            end
            MODE_NUMBER: begin
                if (!eoi && is_digit(c)) begin
                    acc_next = (acc_sum > MW'(VMAX)) ? VMAX : acc_sum[VALUE_BITS-1:0];
                end else begin
                    pre_v     = 1'b1;
                    pre_kind  = KIND_CONST;
                    pre_value = 31'(acc_reg);
                    run_idle  = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (!eoi && (is_alpha(c) || is_digit(c) || c == CH_UNDER)) begin
                    cand_next = kw_feed(cand_reg, len_reg, c);
                    len_next  = (len_reg == 3'd7) ? len_reg : len_reg + 3'd1;
                end else begin
                    pre_v    = 1'b1;
                    pre_kind = kw_finish(cand_reg, len_reg);
                    run_idle = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase
        if (run_idle) begin
            mode_next = idle_mode;
            acc_next  = idle_acc;
            cand_next = idle_cand;
            len_next  = idle_len;
        end
    end

    always_comb begin
        res0 = '{kind: pre_kind, value: pre_value, last: 1'b0};
        res1 = '{kind: idle_kind, value: idle_value, last: 1'b1};
        wr_n = {1'b0, pre_v} + {1'b0, run_idle && idle_v};
        if (!pre_v) begin
            res0 = res1;
        end else if (!(run_idle && idle_v)) begin
            res0.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            cand_reg   <= {NUM_WORDS{1'b1}};
            len_reg    <= 3'd0;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (s_accept) begin
                mode_reg   <= mode_next;
                acc_reg    <= acc_next;
                cand_reg   <= cand_next;
                len_reg    <= len_next;
                wr_ptr_reg <= wr_ptr_reg + wr_n;
            end
            if (m_accept) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (s_accept ? {1'b0, wr_n} : 3'd0)
                         - {2'b0, m_accept};
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && wr_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (s_accept && wr_n == 2'd2) begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {1'b0, queue_reg[rd_ptr_reg].value};
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser) |=> m_tvalid)
        else $error("end of input produced no result");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> count_reg == $past(count_reg) + {1'b0, $past(wr_n)}
                                 - {2'b0, $past(m_accept)})
        else $error("queue count mismatch");

    a_string_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_STRING && s_accept && !s_tuser && s_tdata != CH_QUOTE)
        |=> mode_reg == MODE_STRING)
        else $error("string mode left early");

    a_ident_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDENT) |-> (len_reg != 3'd0))
        else $error("identifier with zero length");
`endif

endmodule
